@@ design/pel_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pel_pkg - shared constants, types and helpers
// Sizes, state encodings and lane set-up functions for the pair entropy unit.
// ----------------------------------------------------------------------------
package pel_pkg;

  localparam int NUM_GENES   = 32;
  localparam int MAX_SAMPLES = 65535;

  localparam int SOL_W  = 32;
  localparam int GIDX_W = 5;
  localparam int CNT_W  = 16;
  localparam int GENE_W = $clog2(NUM_GENES);

  // counter banks
  localparam int LANES  = 4;
  localparam int LANE_W = $clog2(LANES);
  localparam int PAIRS  = NUM_GENES * (NUM_GENES - 1) / 2;
  localparam int ROWS   = (PAIRS + LANES - 1) / LANES;
  localparam int ROWA_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROWC_W = $clog2(ROWS + 1);

  // arithmetic
  localparam int M_W     = 32;
  localparam int C_W     = CNT_W + 2;
  localparam int LOG_E_W = $clog2(C_W);
  localparam int FRAC_W  = 24;
  localparam int Q_FRAC  = 16;
  localparam int L_W     = LOG_E_W + Q_FRAC + 1;
  localparam int P_W     = C_W + L_W;
  localparam int ACC_W   = P_W + 2;
  localparam int SACC_W  = ACC_W + 2;
  localparam int DVS_W   = SACC_W;
  localparam int DVD_W   = DVS_W + Q_FRAC;
  localparam int DIST_W  = 17;
  localparam int ONE_Q16 = 65536;
  localparam int TWO_Q16 = 131072;
  localparam int NUM_TERMS = 9;
  localparam int TERM_W    = $clog2(NUM_TERMS);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [3:0][CNT_W-1:0] cnt_row_t;

  typedef struct packed {
    logic              add_start;
    logic              rd_en;
    logic [ROWA_W-1:0] rd_row;
  } lane_cmd_t;

  typedef enum logic [3:0] {
    T_IDLE, T_ADD, T_RD, T_RDW, T_TERM, T_TWAIT, T_DIV, T_DWAIT, T_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    LG_IDLE, LG_SQ, LG_RND, LG_MUL, LG_DONE
  } log_state_t;

  // first pair (a, b) of the contiguous block of pairs that a lane owns
  function automatic logic [2*GENE_W-1:0] lane_start(input int l);
    int s;
    logic found;
    logic [2*GENE_W-1:0] r;
    s = l * ROWS;
    found = 1'b0;
    r = '0;
    for (int i = 0; i < NUM_GENES; i++) begin
      if (!found) begin
        if (s < NUM_GENES - 1 - i) begin
          r = {GENE_W'(i), GENE_W'(i + 1 + s)};
          found = 1'b1;
        end else begin
          s = s - (NUM_GENES - 1 - i);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [ROWC_W-1:0] lane_rows(input int l);
    int r;
    r = PAIRS - l * ROWS;
    if (r < 0) r = 0;
    if (r > ROWS) r = ROWS;
    return ROWC_W'(r);
  endfunction

  // genes beyond the solution width read as zero
  function automatic logic gene_bit(input logic [SOL_W-1:0] sol,
                                    input logic [GENE_W-1:0] g);
    logic r;
    r = 1'b0;
    for (int i = 0; i < SOL_W; i++) begin
      if (int'(g) == i) r = sol[i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/pel_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pel_lane - one bank of pair counters
// Holds four counters per pair for a block of pairs; sweeps them on an add
// (read-modify-write, one pair a cycle) and serves single row reads.
// ----------------------------------------------------------------------------
module pel_lane (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [pel_pkg::GENE_W-1:0]   start_a,
  input  wire logic [pel_pkg::GENE_W-1:0]   start_b,
  input  wire logic [pel_pkg::ROWC_W-1:0]   rows,
  input  wire logic [pel_pkg::SOL_W-1:0]    solution,
  input  wire pel_pkg::lane_cmd_t           cmd,
  output logic                              busy,
  output pel_pkg::cnt_row_t                 rd_data
);

  pel_pkg::cnt_row_t mem [pel_pkg::ROWS];

  logic                         clr;
  logic [pel_pkg::ROWA_W-1:0]   clr_row;
  logic                         sweeping;
  logic [pel_pkg::ROWC_W-1:0]   row;
  logic [pel_pkg::GENE_W-1:0]   ga;
  logic [pel_pkg::GENE_W-1:0]   gb;
  logic                         wr_pend;
  logic [pel_pkg::ROWA_W-1:0]   wr_row;
  logic [1:0]                   wr_sel;
  logic [pel_pkg::ROWA_W-1:0]   rd_addr;
  pel_pkg::cnt_row_t            wr_data;

  assign busy    = clr || sweeping || wr_pend;
  assign rd_addr = sweeping ? row[pel_pkg::ROWA_W-1:0] : cmd.rd_row;

  always_comb begin
    wr_data = rd_data;
    wr_data[wr_sel] = rd_data[wr_sel] + pel_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr      <= 1'b1;
      clr_row  <= '0;
      sweeping <= 1'b0;
      wr_pend  <= 1'b0;
    end else begin
      if (clr) begin
        clr_row <= clr_row + pel_pkg::ROWA_W'(1);
        if (int'(clr_row) == pel_pkg::ROWS - 1) clr <= 1'b0;
      end
      wr_pend <= sweeping;
      if (cmd.add_start && rows != '0) begin
        sweeping <= 1'b1;
      end else if (sweeping && row == rows - pel_pkg::ROWC_W'(1)) begin
        sweeping <= 1'b0;
      end
    end
  end

  // walker over the lane's pairs
  always_ff @(posedge clk) begin
    if (cmd.add_start) begin
      row <= '0;
      ga  <= start_a;
      gb  <= start_b;
    end else if (sweeping) begin
      row    <= row + pel_pkg::ROWC_W'(1);
      wr_row <= row[pel_pkg::ROWA_W-1:0];
      wr_sel <= {pel_pkg::gene_bit(solution, gb), pel_pkg::gene_bit(solution, ga)};
      if (int'(gb) == pel_pkg::NUM_GENES - 1) begin
        ga <= ga + pel_pkg::GENE_W'(1);
        gb <= ga + pel_pkg::GENE_W'(2);
      end else begin
        gb <= gb + pel_pkg::GENE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweeping || cmd.rd_en) rd_data <= mem[rd_addr];
    if (clr) begin
      mem[clr_row] <= '0;
    end else if (wr_pend) begin
      mem[wr_row] <= wr_data;
    end
  end

endmodule
`default_nettype wire

@@ design/pel_log.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pel_log - c * log2(c) unit
// Normalises c, makes 24 fraction bits by repeated squaring, rounds to Q.16
// and multiplies by c, one term at a time.
// ----------------------------------------------------------------------------
module pel_log (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [pel_pkg::C_W-1:0]   c,
  output logic                           done,
  output logic [pel_pkg::P_W-1:0]        clogc
);

  pel_pkg::log_state_t st, st_next;

  logic [pel_pkg::C_W-1:0]     c_q;
  logic [pel_pkg::LOG_E_W-1:0] e, e_in;
  logic [pel_pkg::M_W-1:0]     m, m_in, cx;
  logic [pel_pkg::FRAC_W-1:0]  frac;
  logic [4:0]                  k;
  logic [pel_pkg::L_W-1:0]     lval;
  logic [2*pel_pkg::M_W-1:0]   sq;
  logic [pel_pkg::M_W:0]       sh;
  logic [pel_pkg::FRAC_W:0]    rnd;

  always_comb begin
    e_in = '0;
    for (int i = 0; i < pel_pkg::C_W; i++) begin
      if (c[i]) e_in = pel_pkg::LOG_E_W'(i);
    end
  end

  assign cx   = pel_pkg::M_W'(c);
  assign m_in = cx << (pel_pkg::LOG_E_W'(pel_pkg::M_W - 1) - e_in);
  assign sq   = (2 * pel_pkg::M_W)'(m) * (2 * pel_pkg::M_W)'(m);
  assign sh   = sq[2*pel_pkg::M_W-1:pel_pkg::M_W-1];
  assign rnd  = (pel_pkg::FRAC_W + 1)'(frac) + (pel_pkg::FRAC_W + 1)'(128);

  always_comb begin
    st_next = st;
    case (st)
      pel_pkg::LG_IDLE: if (start) st_next = pel_pkg::LG_SQ;
      pel_pkg::LG_SQ:   if (int'(k) == pel_pkg::FRAC_W - 1) st_next = pel_pkg::LG_RND;
      pel_pkg::LG_RND:  st_next = pel_pkg::LG_MUL;
      pel_pkg::LG_MUL:  st_next = pel_pkg::LG_DONE;
      pel_pkg::LG_DONE: st_next = pel_pkg::LG_IDLE;
      default:          st_next = pel_pkg::LG_IDLE;
    endcase
  end

  always_comb begin
    done = (st == pel_pkg::LG_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) st <= pel_pkg::LG_IDLE;
    else     st <= st_next;
  end

  always_ff @(posedge clk) begin
    case (st)
      pel_pkg::LG_IDLE: begin
        c_q  <= c;
        e    <= e_in;
        m    <= m_in;
        frac <= '0;
        k    <= '0;
      end
      pel_pkg::LG_SQ: begin
        k <= k + 5'd1;
        if (sh[pel_pkg::M_W]) begin
          frac <= {frac[pel_pkg::FRAC_W-2:0], 1'b1};
          m    <= sh[pel_pkg::M_W:1];
        end else begin
          frac <= {frac[pel_pkg::FRAC_W-2:0], 1'b0};
          m    <= sh[pel_pkg::M_W-1:0];
        end
      end
      pel_pkg::LG_RND: lval <= (pel_pkg::L_W'(e) << pel_pkg::Q_FRAC)
                      + pel_pkg::L_W'(rnd[pel_pkg::FRAC_W:pel_pkg::FRAC_W-pel_pkg::Q_FRAC]);
      pel_pkg::LG_MUL: clogc <= pel_pkg::P_W'(c_q) * pel_pkg::P_W'(lval);
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ design/pel_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pel_div - restoring divider
// Unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pel_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pel_pkg::DVD_W-1:0]   dividend,
  input  wire logic [pel_pkg::DVS_W-1:0]   divisor,
  output logic                             done,
  output logic [pel_pkg::DVD_W-1:0]        quotient
);

  localparam int CW = $clog2(pel_pkg::DVD_W + 1);

  logic                        busy;
  logic [CW-1:0]               cnt;
  logic [pel_pkg::DVS_W:0]     rem, rem2;
  logic [pel_pkg::DVS_W-1:0]   dvs;
  logic                        ge;

  assign rem2 = {rem[pel_pkg::DVS_W-1:0], quotient[pel_pkg::DVD_W-1]};
  assign ge   = rem2 >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && int'(cnt) == pel_pkg::DVD_W - 1;
      if (start) busy <= 1'b1;
      else if (busy && int'(cnt) == pel_pkg::DVD_W - 1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
      cnt      <= '0;
    end else if (busy) begin
      cnt      <= cnt + CW'(1);
      rem      <= ge ? rem2 - {1'b0, dvs} : rem2;
      quotient <= {quotient[pel_pkg::DVD_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ design/pairwise_entropy_linkage_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pairwise_entropy_linkage_unit - gene pair linkage distance
// Counts binary samples per gene pair and answers 2 - Hsep/Hjoint queries.
// ----------------------------------------------------------------------------
// Each item is either an add (tuser 0) or a query (tuser 1) and gives exactly
// one result item. The 496 pairs are split across four lanes of 124 rows,
// each row holding the four joint counters of one pair; an add sweeps all
// lanes at once, one read-modify-write per lane per cycle. A query reads one
// row, then runs nine c*log2(c) terms through the shared squaring log unit
// and a serial restoring divide. Refused adds and invalid queries answer
// without a lane sweep or any arithmetic. One item is worked on at a time.
// After reset the counter banks are cleared row by row before the first
// item is taken. Distances are unsigned Q1.16, 65536 being one.
// ----------------------------------------------------------------------------
module pairwise_entropy_linkage_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // solution[31:0], first_gene[36:32], second_gene[41:37], zero fill
  input  wire logic [47:0] s_axis_tdata,
  // operation[0]
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // distance[16:0], accepted[17], sample_count[33:18], zero fill
  output logic [39:0]      m_axis_tdata
);

  pel_pkg::top_state_t state, state_next;

  // input fields
  logic                         in_op;
  logic [pel_pkg::SOL_W-1:0]    in_sol;
  logic [pel_pkg::GIDX_W-1:0]   in_x, in_y, lo, hi;
  logic                         accept, q_valid, room;
  int                           p_int;
  logic [pel_pkg::LANE_W-1:0]   lane_in;
  logic [pel_pkg::ROWA_W-1:0]   row_in;

  assign in_op  = s_axis_tuser[0];
  assign in_sol = s_axis_tdata[31:0];
  assign in_x   = s_axis_tdata[36:32];
  assign in_y   = s_axis_tdata[41:37];

  // lanes
  pel_pkg::lane_cmd_t           cmd;
  logic [pel_pkg::LANES-1:0]    lane_busy;
  pel_pkg::cnt_row_t            lane_data [pel_pkg::LANES];
  logic                         lanes_busy;

  // held item and arithmetic
  logic [pel_pkg::CNT_W-1:0]    samples;
  logic [pel_pkg::SOL_W-1:0]    sol_q;
  logic [pel_pkg::LANE_W-1:0]   lane_q;
  logic [pel_pkg::ROWA_W-1:0]   row_q;
  pel_pkg::cnt_row_t            ev;
  logic [pel_pkg::TERM_W-1:0]   term;
  logic [pel_pkg::C_W-1:0]      term_c;
  logic [pel_pkg::ACC_W-1:0]    nl, sm, sj;
  logic signed [pel_pkg::SACC_W-1:0] num, den;
  logic                         neg;
  logic                         log_start, log_done;
  logic [pel_pkg::P_W-1:0]      clogc;
  logic                         div_start, div_done;
  logic [pel_pkg::DVD_W-1:0]    div_quo;
  logic [pel_pkg::DVD_W-1:0]    dvd;
  logic [pel_pkg::DVS_W-1:0]    dvs;
  logic [pel_pkg::DIST_W-1:0]   dist_div;
  logic [pel_pkg::DIST_W:0]     d18;

  // result
  logic [pel_pkg::DIST_W-1:0]   res_dist;
  logic                         res_acc;
  logic                         out_load;
  logic [pel_pkg::DIST_W-1:0]   out_dist;
  logic                         out_acc;
  logic [pel_pkg::CNT_W-1:0]    out_cnt;

  assign lanes_busy    = |lane_busy;
  assign s_axis_tready = (state == pel_pkg::T_IDLE) && !lanes_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign room          = int'(samples) < pel_pkg::MAX_SAMPLES;
  assign m_axis_tdata  = {6'b0, out_cnt, out_acc, out_dist};

  // ---- query decode: ordered pair, flat pair index, lane and row ----------
  assign q_valid = (in_x != in_y) && (int'(in_x) < pel_pkg::NUM_GENES)
                   && (int'(in_y) < pel_pkg::NUM_GENES);
  assign lo = (in_x < in_y) ? in_x : in_y;
  assign hi = (in_x < in_y) ? in_y : in_x;

  always_comb begin
    p_int   = ((int'(lo) * (2 * pel_pkg::NUM_GENES - 1 - int'(lo))) >> 1)
              + int'(hi) - int'(lo) - 1;
    lane_in = '0;
    for (int l = 0; l < pel_pkg::LANES; l++) begin
      if (p_int >= l * pel_pkg::ROWS) lane_in = pel_pkg::LANE_W'(l);
    end
    row_in = pel_pkg::ROWA_W'(p_int - int'(lane_in) * pel_pkg::ROWS);
  end

  // ---- counter lanes ------------------------------------------------------
  for (genvar l = 0; l < pel_pkg::LANES; l++) begin : g_lane
    localparam logic [2*pel_pkg::GENE_W-1:0] START = pel_pkg::lane_start(l);
    pel_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .start_a  (START[2*pel_pkg::GENE_W-1:pel_pkg::GENE_W]),
      .start_b  (START[pel_pkg::GENE_W-1:0]),
      .rows     (pel_pkg::lane_rows(l)),
      .solution (sol_q),
      .cmd      (cmd),
      .busy     (lane_busy[l]),
      .rd_data  (lane_data[l])
    );
  end

  // ---- shared arithmetic units --------------------------------------------
  always_comb begin
    case (term)
      4'd0:    term_c = pel_pkg::C_W'(ev[0]) + pel_pkg::C_W'(ev[1])
                        + pel_pkg::C_W'(ev[2]) + pel_pkg::C_W'(ev[3]);
      4'd1:    term_c = pel_pkg::C_W'(ev[0]) + pel_pkg::C_W'(ev[2]);
      4'd2:    term_c = pel_pkg::C_W'(ev[1]) + pel_pkg::C_W'(ev[3]);
      4'd3:    term_c = pel_pkg::C_W'(ev[0]) + pel_pkg::C_W'(ev[1]);
      4'd4:    term_c = pel_pkg::C_W'(ev[2]) + pel_pkg::C_W'(ev[3]);
      4'd5:    term_c = pel_pkg::C_W'(ev[0]);
      4'd6:    term_c = pel_pkg::C_W'(ev[1]);
      4'd7:    term_c = pel_pkg::C_W'(ev[2]);
      4'd8:    term_c = pel_pkg::C_W'(ev[3]);
      default: term_c = '0;
    endcase
  end

  pel_log u_log (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .c     (term_c),
    .done  (log_done),
    .clogc (clogc)
  );

  // marginal and joint sums against the total
  assign num = (pel_pkg::SACC_W'(nl) <<< 1) - pel_pkg::SACC_W'(sm);
  assign den = pel_pkg::SACC_W'(nl) - pel_pkg::SACC_W'(sj);
  assign dvd = pel_pkg::DVD_W'(num[pel_pkg::SACC_W-1] ? -num : num) << pel_pkg::Q_FRAC;
  assign dvs = pel_pkg::DVS_W'(den[pel_pkg::SACC_W-1] ? -den : den);

  pel_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // 2 - ratio, clamped to 0..1; a negative ratio always clamps to one
  always_comb begin
    d18 = (pel_pkg::DIST_W + 1)'(pel_pkg::TWO_Q16) - div_quo[pel_pkg::DIST_W:0];
    if (neg) begin
      dist_div = pel_pkg::DIST_W'(pel_pkg::ONE_Q16);
    end else if (div_quo >= pel_pkg::DVD_W'(pel_pkg::TWO_Q16)) begin
      dist_div = '0;
    end else if (d18 > (pel_pkg::DIST_W + 1)'(pel_pkg::ONE_Q16)) begin
      dist_div = pel_pkg::DIST_W'(pel_pkg::ONE_Q16);
    end else begin
      dist_div = d18[pel_pkg::DIST_W-1:0];
    end
  end

  // ---- sequencer ----------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      pel_pkg::T_IDLE: begin
        if (accept) begin
          if (in_op == pel_pkg::OP_ADD) state_next = room ? pel_pkg::T_ADD : pel_pkg::T_OUT;
          else state_next = q_valid ? pel_pkg::T_RD : pel_pkg::T_OUT;
        end
      end
      pel_pkg::T_ADD:   if (!lanes_busy) state_next = pel_pkg::T_OUT;
      pel_pkg::T_RD:    state_next = pel_pkg::T_RDW;
      pel_pkg::T_RDW:   state_next = pel_pkg::T_TERM;
      pel_pkg::T_TERM:  state_next = pel_pkg::T_TWAIT;
      pel_pkg::T_TWAIT: begin
        if (log_done) begin
          state_next = (int'(term) == pel_pkg::NUM_TERMS - 1) ? pel_pkg::T_DIV
                                                              : pel_pkg::T_TERM;
        end
      end
      pel_pkg::T_DIV:   state_next = (den == '0) ? pel_pkg::T_OUT : pel_pkg::T_DWAIT;
      pel_pkg::T_DWAIT: if (div_done) state_next = pel_pkg::T_OUT;
      pel_pkg::T_OUT:   if (!m_axis_tvalid || m_axis_tready) state_next = pel_pkg::T_IDLE;
      default:          state_next = pel_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    cmd.add_start = (state == pel_pkg::T_IDLE) && accept && in_op == pel_pkg::OP_ADD && room;
    cmd.rd_en     = (state == pel_pkg::T_RD);
    cmd.rd_row    = row_q;
    log_start     = (state == pel_pkg::T_TERM);
    div_start     = (state == pel_pkg::T_DIV) && den != '0;
    out_load      = (state == pel_pkg::T_OUT) && (!m_axis_tvalid || m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pel_pkg::T_IDLE;
      samples       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.add_start) samples <= samples + pel_pkg::CNT_W'(1);
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sol_q    <= in_sol;
      lane_q   <= lane_in;
      row_q    <= row_in;
      res_dist <= '0;
      res_acc  <= (in_op == pel_pkg::OP_ADD) ? room : q_valid;
    end
    if (state == pel_pkg::T_RDW) begin
      ev   <= lane_data[lane_q];
      term <= '0;
      nl   <= '0;
      sm   <= '0;
      sj   <= '0;
    end
    if (state == pel_pkg::T_TWAIT && log_done) begin
      term <= term + pel_pkg::TERM_W'(1);
      if (term == '0) nl <= pel_pkg::ACC_W'(clogc);
      else if (int'(term) < 5) sm <= sm + pel_pkg::ACC_W'(clogc);
      else sj <= sj + pel_pkg::ACC_W'(clogc);
    end
    if (state == pel_pkg::T_DIV) begin
      neg <= num[pel_pkg::SACC_W-1] ^ den[pel_pkg::SACC_W-1];
      if (den == '0) res_dist <= pel_pkg::DIST_W'(pel_pkg::ONE_Q16);
    end
    if (state == pel_pkg::T_DWAIT && div_done) res_dist <= dist_div;
    if (out_load) begin
      out_dist <= res_dist;
      out_acc  <= res_acc;
      out_cnt  <= samples;
    end
  end

  // ---- checks -------------------------------------------------------------
  a_ready_needs_idle_banks: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !lanes_busy)
    else $error("item taken while counter banks busy");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_dist <= pel_pkg::DIST_W'(pel_pkg::ONE_Q16))
    else $error("distance above one");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !out_acc |-> out_dist == '0)
    else $error("refused item carries a distance");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.add_start |=> samples != '0 && int'(samples) <= pel_pkg::MAX_SAMPLES)
    else $error("sample count overrun");

endmodule
`default_nettype wire

@@ bench/pairwise_entropy_linkage_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_entropy_linkage_checker - result checker for the linkage unit
// Watches both streams, keeps its own pair counters and predicts each result.
// ----------------------------------------------------------------------------
module pairwise_entropy_linkage_checker
  import pel_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic [0:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [39:0] m_axis_tdata,
  output int               fail_count,
  output int               pending
);

  // packed from the top bit down: sample_count, accepted, distance
  typedef struct packed {
    logic [15:0] sample_count;
    logic        accepted;
    logic [16:0] distance;
  } linkage_answer_t;

  logic [15:0] joint_cnt [PAIRS*4];
  logic [15:0] samples_held;
  linkage_answer_t answer_q[$];

  function automatic int row_of(int a, int b);
    return 4 * (a * (2 * NUM_GENES - a - 1) / 2 + (b - a - 1));
  endfunction

  function automatic longint log2_fix(longint unsigned c);
    int e;
    longint unsigned m;
    longint unsigned frac;
    e = 0;
    frac = 0;
    while (e < 31 && (c >> (e + 1)) != 0) e++;
    m = c << (31 - e);
    for (int k = 0; k < 24; k++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(e) * 65536 + longint'((frac + 128) >> 8);
  endfunction

  function automatic longint clogc(longint unsigned c);
    if (c == 0) return 0;
    return longint'(c) * log2_fix(c);
  endfunction

  function automatic logic [16:0] pair_dist(int a, int b);
    int base;
    longint unsigned e0, e1, e2, e3, n;
    longint nl, sm, sj, num, den, ratio, d;
    base = row_of(a, b);
    e0 = joint_cnt[base];
    e1 = joint_cnt[base+1];
    e2 = joint_cnt[base+2];
    e3 = joint_cnt[base+3];
    n = e0 + e1 + e2 + e3;
    nl = clogc(n);
    sm = clogc(e0 + e2) + clogc(e1 + e3) + clogc(e0 + e1) + clogc(e2 + e3);
    sj = clogc(e0) + clogc(e1) + clogc(e2) + clogc(e3);
    num = 2 * nl - sm;
    den = nl - sj;
    if (den == 0) return 17'(ONE_Q16);
    ratio = (num * 65536) / den;
    d = 131072 - ratio;
    if (d < 0) d = 0;
    if (d > ONE_Q16) d = ONE_Q16;
    return 17'(d);
  endfunction

  function automatic linkage_answer_t apply_item(logic op, logic [31:0] sol,
                                                 int x, int y);
    linkage_answer_t r;
    int t;
    r = '0;
    if (op == OP_ADD) begin
      if (samples_held < 16'(MAX_SAMPLES)) begin
        for (int a = 0; a < NUM_GENES - 1; a++)
          for (int b = a + 1; b < NUM_GENES; b++) begin
            t = row_of(a, b) + 2 * sol[b] + sol[a];
            joint_cnt[t] = joint_cnt[t] + 16'd1;
          end
        samples_held = samples_held + 16'd1;
        r.accepted = 1'b1;
      end
    end else if (x != y && x < NUM_GENES && y < NUM_GENES) begin
      if (x > y) begin
        t = x; x = y; y = t;
      end
      r.distance = pair_dist(x, y);
      r.accepted = 1'b1;
    end
    r.sample_count = samples_held;
    return r;
  endfunction

  assign pending = answer_q.size();

  always @(posedge clk) begin
    linkage_answer_t got, want;
    if (rst) begin
      for (int i = 0; i < PAIRS * 4; i++) joint_cnt[i] = '0;
      samples_held = '0;
      answer_q.delete();
      fail_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        answer_q.insert(answer_q.size(),
                        apply_item(s_axis_tuser[0], s_axis_tdata[31:0],
                                   int'(s_axis_tdata[36:32]),
                                   int'(s_axis_tdata[41:37])));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[33:0];
        if (answer_q.size() == 0) begin
          $error("result with nothing expected: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = answer_q.pop_front();
          if (got != want) fail_count <= fail_count + 1;
          if (got.distance != want.distance)
            $error("distance: expected %0d, got %0d", want.distance, got.distance);
          if (got.accepted != want.accepted)
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
          if (got.sample_count != want.sample_count)
            $error("sample_count: expected %0d, got %0d",
                   want.sample_count, got.sample_count);
        end
      end
    end
  end

endmodule

@@ bench/pairwise_entropy_linkage_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_entropy_linkage_unit_test - top of the linkage unit bench
// Directed then random adds and queries under varied stream back-pressure.
// ----------------------------------------------------------------------------
module pairwise_entropy_linkage_unit_test;
  import pel_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;

  pairwise_entropy_linkage_unit u_top (.*);

  pairwise_entropy_linkage_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver back-pressure, fresh draw every cycle
  always @(posedge clk)
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one item: optional idle gap, then hold until taken
  task automatic send_item(logic op, logic [31:0] sol, logic [4:0] ga,
                           logic [4:0] gb);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, gb, ga, sol};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic random_item();
    logic [31:0] sol;
    // queries a bit more often than adds keep the 496-pair sweep in check
    if ($urandom_range(99) < 45) begin
      case ($urandom_range(3))
        0: sol = $urandom;
        1: sol = '0;
        2: sol = '1;
        default: sol = $urandom & $urandom;
      endcase
      send_item(OP_ADD, sol, 5'($urandom), 5'($urandom));
    end else begin
      if ($urandom_range(9) == 0)
        send_item(OP_QUERY, $urandom, 5'($urandom), 5'($urandom));
      else
        send_item(OP_QUERY, $urandom, 5'($urandom_range(3)),
                  5'($urandom_range(31)));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 48;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty counters: zero denominator, equal pair
    send_item(OP_QUERY, '0, 5'd0, 5'd1);
    send_item(OP_QUERY, '1, 5'd31, 5'd0);
    send_item(OP_QUERY, '0, 5'd7, 5'd7);
    // all samples in one joint cell still gives one
    send_item(OP_ADD, '0, 5'd0, 5'd0);
    send_item(OP_ADD, '0, 5'd31, 5'd31);
    send_item(OP_QUERY, '0, 5'd3, 5'd9);
    send_item(OP_ADD, '1, 5'd0, 5'd0);
    send_item(OP_ADD, 32'hAAAA_AAAA, 5'd0, 5'd0);
    send_item(OP_ADD, 32'h5555_5555, 5'd0, 5'd0);
    send_item(OP_ADD, 32'h0000_FFFF, 5'd0, 5'd0);
    send_item(OP_ADD, 32'hFFFF_0000, 5'd0, 5'd0);
    send_item(OP_QUERY, '0, 5'd0, 5'd1);
    send_item(OP_QUERY, '0, 5'd1, 5'd0);
    send_item(OP_QUERY, '0, 5'd0, 5'd2);
    send_item(OP_QUERY, '0, 5'd15, 5'd16);
    send_item(OP_QUERY, '0, 5'd30, 5'd31);
    send_item(OP_QUERY, '1, 5'd31, 5'd31);
    send_item(OP_ADD, 32'h8000_0001, 5'd0, 5'd0);
    send_item(OP_QUERY, '0, 5'd0, 5'd31);

    for (int i = 0; i < 750; i++) begin
      if (i == 250) begin
        send_idle_pct = 48;
        recv_idle_pct = 17;
      end else if (i == 500) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_item();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/pel_pkg.sv
design/pel_lane.sv
design/pel_log.sv
design/pel_div.sv
design/pairwise_entropy_linkage_unit.sv
bench/pairwise_entropy_linkage_checker.sv
bench/pairwise_entropy_linkage_unit_test.sv
